>>> rtl/assert_macros.svh
// assertion macros used by the checker file dtb_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depth_test_buffer check failed");

// next-cycle implication, disabled while reset is asserted
`define DTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depth_test_buffer check failed");

`endif

>>> rtl/dtb_pkg.sv
// types and constants of the depth test buffer
// no dependencies
package dtb_pkg;

    localparam int FIELD_DEPTH_BITS = 24;
    localparam int TOL_BITS         = 24;
    localparam int DIM_BITS         = 9;
    localparam int COORD_BITS       = 16;
    localparam int CFG_IDX_BITS     = 2;
    localparam int EPOCH_BITS       = 8;

    localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    localparam logic [TOL_BITS-1:0] TOL_LINEAR_RESET  = TOL_BITS'(1);
    localparam logic [TOL_BITS-1:0] TOL_SQUARED_RESET = TOL_BITS'(102);

    typedef enum logic [2:0] {
        REQ_TEST_SET = 3'd0,
        REQ_TEST     = 3'd1,
        REQ_SET      = 3'd2,
        REQ_GET      = 3'd3,
        REQ_CLEAR    = 3'd4
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACTIVE_WIDTH      = 2'd0,
        CFG_ACTIVE_HEIGHT     = 2'd1,
        CFG_TOLERANCE_LINEAR  = 2'd2,
        CFG_TOLERANCE_SQUARED = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic [2:0]                  req_type;
        logic signed [COORD_BITS-1:0] col;
        logic signed [COORD_BITS-1:0] row;
        logic [FIELD_DEPTH_BITS-1:0] depth_in;
        logic                        squared_mode;
    } t_in_item;

    typedef struct packed {
        logic                        pass_flag;
        logic [FIELD_DEPTH_BITS-1:0] depth_out;
    } t_out_item;

endpackage

>>> rtl/depth_test_buffer_top.sv
// depth test buffer top level: configuration registers and block wiring
// depends on dtb_pkg, dtb_locate, dtb_mem, dtb_ctrl
//
// Per-pixel depth store for MAX_WIDTH x MAX_HEIGHT pixels, addressed row-major,
// with test-and-set, test, set, get and clear transactions. Each transaction
// goes through register and locate, memory read, then compare and write back,
// and the next one is taken once the previous is written back; the single port
// pair of the depth memory sets this. A result waits in an output register; the
// next transaction is still taken, but its compare cycle waits, with o_in_stall
// high, until that result has left. Clear is done with an 8-bit epoch
// tag kept next to each depth: a clear advances the tag and takes its depth as
// the cleared value; every 255th clear, as well as reset, starts a sweep that
// retags the whole memory, during which o_in_stall stays high. Configuration
// writes are accepted at any time but should only be made while idle.
module depth_test_buffer_top
    import dtb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [TOL_BITS-1:0]     i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_item
);

    localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int MW     = EPOCH_BITS + DEPTH_BITS;

    logic [DIM_BITS-1:0] r_active_width;
    logic [DIM_BITS-1:0] r_active_height;
    logic [TOL_BITS-1:0] r_tol_linear;
    logic [TOL_BITS-1:0] r_tol_squared;

    logic          loc_ok;
    logic [AW-1:0] loc_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [MW-1:0] mem_wdata;
    logic [MW-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= '0;
            r_active_height <= '0;
            r_tol_linear    <= TOL_LINEAR_RESET;
            r_tol_squared   <= TOL_SQUARED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ACTIVE_WIDTH:      r_active_width  <= i_cfg_wdata[DIM_BITS-1:0];
                CFG_ACTIVE_HEIGHT:     r_active_height <= i_cfg_wdata[DIM_BITS-1:0];
                CFG_TOLERANCE_LINEAR:  r_tol_linear    <= i_cfg_wdata;
                CFG_TOLERANCE_SQUARED: r_tol_squared   <= i_cfg_wdata;
                default: begin
                    r_tol_linear <= r_tol_linear;
                end
            endcase
        end
    end

    dtb_locate #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_locate (
        .i_col           (i_in_item.col),
        .i_row           (i_in_item.row),
        .i_active_width  (r_active_width),
        .i_active_height (r_active_height),
        .o_ok            (loc_ok),
        .o_addr          (loc_addr)
    );

    dtb_mem #(
        .AW    (AW),
        .DEPTH (PIXELS),
        .MW    (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dtb_ctrl #(
        .AW    (AW),
        .DW    (DEPTH_BITS),
        .DEPTH (PIXELS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_ok          (loc_ok),
        .i_addr        (loc_addr),
        .i_tol_linear  (r_tol_linear),
        .i_tol_squared (r_tol_squared),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

endmodule

>>> rtl/dtb_mem.sv
// depth and epoch tag memory, one write port, one registered read port
// depends on nothing but its parameters
module dtb_mem #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536,
    parameter int MW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [MW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [MW-1:0] o_rdata
);

    logic [MW-1:0] r_mem [DEPTH];
    logic [MW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dtb_locate.sv
// bounds check and row-major address of one pixel
// depends on dtb_pkg
module dtb_locate
    import dtb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int AW         = 16
) (
    input  logic signed [COORD_BITS-1:0] i_col,
    input  logic signed [COORD_BITS-1:0] i_row,
    input  logic [DIM_BITS-1:0]          i_active_width,
    input  logic [DIM_BITS-1:0]          i_active_height,
    output logic                         o_ok,
    output logic [AW-1:0]                o_addr
);

    logic [COORD_BITS-1:0] col_u;
    logic [COORD_BITS-1:0] row_u;
    logic [COORD_BITS-1:0] w_lim;
    logic [COORD_BITS-1:0] h_lim;
    logic [31:0]           lin;

    always_comb begin
        col_u = i_col;
        row_u = i_row;
        w_lim = (COORD_BITS'(i_active_width) < COORD_BITS'(MAX_WIDTH)) ?
                COORD_BITS'(i_active_width) : COORD_BITS'(MAX_WIDTH);
        h_lim = (COORD_BITS'(i_active_height) < COORD_BITS'(MAX_HEIGHT)) ?
                COORD_BITS'(i_active_height) : COORD_BITS'(MAX_HEIGHT);
        o_ok  = !col_u[COORD_BITS-1] && !row_u[COORD_BITS-1] &&
                (col_u < w_lim) && (row_u < h_lim);
        lin   = 32'(row_u) * 32'(MAX_WIDTH) + 32'(col_u);
        o_addr = lin[AW-1:0];
    end

endmodule

>>> rtl/dtb_ctrl.sv
// sequencer: read, depth compare, write back, clear sweep, result register
// depends on dtb_pkg, drives dtb_mem
module dtb_ctrl
    import dtb_pkg::*;
#(
    parameter int AW    = 16,
    parameter int DW    = 24,
    parameter int DEPTH = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_in_item                   i_in_item,
    input  logic                       i_ok,
    input  logic [AW-1:0]              i_addr,
    input  logic [TOL_BITS-1:0]        i_tol_linear,
    input  logic [TOL_BITS-1:0]        i_tol_squared,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_out_item                  o_out_item,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [EPOCH_BITS+DW-1:0]   o_mem_wdata,
    output logic [AW-1:0]              o_mem_raddr,
    input  logic [EPOCH_BITS+DW-1:0]   i_mem_rdata
);

    localparam int SW = ((DW > TOL_BITS) ? DW : TOL_BITS) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state                r_state, n_state;
    logic [2:0]            r_req;
    logic [DW-1:0]         r_depth;
    logic [TOL_BITS-1:0]   r_eps;
    logic                  r_ok;
    logic [AW-1:0]         r_addr;
    logic [DW-1:0]         r_cleared, n_cleared;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [AW-1:0]         r_sweep, n_sweep;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_acc;
    logic                  out_free;
    logic [EPOCH_BITS-1:0] rd_tag;
    logic [DW-1:0]         rd_depth;
    logic [DW-1:0]         stored;
    logic [SW-1:0]         limit;
    logic                  ev_pass;
    logic                  ev_wr;
    logic                  ev_clr;
    logic [DW-1:0]         ev_dout;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_tag   = i_mem_rdata[EPOCH_BITS+DW-1:DW];
    assign rd_depth = i_mem_rdata[DW-1:0];
    assign stored   = (rd_tag == r_epoch) ? rd_depth : r_cleared;
    assign limit    = SW'(stored) + SW'(r_eps);

    // evaluation of the request held in r_req against the read pixel
    always_comb begin
        ev_pass = 1'b0;
        ev_wr   = 1'b0;
        ev_clr  = 1'b0;
        ev_dout = '0;
        case (r_req)
            REQ_TEST_SET: begin
                if (r_ok && (SW'(r_depth) <= limit)) begin
                    ev_pass = 1'b1;
                    ev_wr   = 1'b1;
                end
            end
            REQ_TEST: begin
                ev_pass = r_ok && (r_depth < stored);
            end
            REQ_SET: begin
                ev_wr = r_ok;
            end
            REQ_GET: begin
                ev_dout = r_ok ? stored : '1;
            end
            REQ_CLEAR: begin
                ev_clr = 1'b1;
            end
            default: begin
                ev_pass = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cleared   = r_cleared;
        n_epoch     = r_epoch;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = {r_epoch, r_depth};
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.pass_flag = ev_pass;
                    n_out.depth_out = FIELD_DEPTH_BITS'(ev_dout);
                    o_mem_we        = ev_wr;
                    n_state         = ST_IDLE;
                    if (ev_clr) begin
                        n_cleared = r_depth;
                        if (r_epoch == EPOCH_LAST) begin
                            // tags are about to repeat: wipe them all
                            n_epoch = EPOCH_FIRST;
                            n_sweep = '0;
                            n_state = ST_SWEEP;
                        end else begin
                            n_epoch = r_epoch + EPOCH_BITS'(1);
                        end
                    end
                end
            end
            ST_SWEEP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_sweep;
                o_mem_wdata = {EPOCH_NONE, {DW{1'b0}}};
                n_sweep     = r_sweep + AW'(1);
                if (r_sweep == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_cleared   <= '1;
            r_epoch     <= EPOCH_FIRST;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cleared   <= n_cleared;
            r_epoch     <= n_epoch;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_req   <= i_in_item.req_type;
            r_depth <= DW'(i_in_item.depth_in);
            r_eps   <= i_in_item.squared_mode ? i_tol_squared : i_tol_linear;
            r_ok    <= i_ok;
            r_addr  <= i_addr;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_mem_raddr = r_addr;

endmodule

>>> rtl/dtb_checker.sv
// port-level checks of the depth test buffer, bound to the top level
// depends on dtb_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtb_checker
    import dtb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic in_acc;
    logic acc_free;
    logic out_held;
    logic out_zero;
    logic no_data_req;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign acc_free    = in_acc && !o_out_valid;
    assign out_held    = o_out_valid && i_out_stall;
    assign out_zero    = !o_out_item.pass_flag && (o_out_item.depth_out == '0);
    assign no_data_req = (i_in_item.req_type == REQ_SET) ||
                         (i_in_item.req_type == REQ_CLEAR);

    // a stalled result holds
    `DTB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_item))

    // one transaction at a time
    `DTB_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall)

    // with the result slot empty, the result shows once the request has passed the read and compare states
    `DTB_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, acc_free, ##3 o_out_valid)

    // set and clear give an all-zero result
    `DTB_ASSERT_IMP(a_set_clear_zero, i_clk, i_rst_n, acc_free && no_data_req, ##3 out_zero)

endmodule

bind depth_test_buffer_top dtb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
